FILE: hw/rtl/snoise3d_pkg.sv
// Shared constants and helpers for the 3D simplex noise unit.
`default_nettype none
package snoise3d_pkg;

  // Permutation table used to hash lattice corners
  localparam logic [7:0] PERM [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15, 8'd131, 8'd13, 8'd201, 8'd95,
    8'd96, 8'd53, 8'd194, 8'd233, 8'd7, 8'd225, 8'd140, 8'd36, 8'd103, 8'd30,
    8'd69, 8'd142, 8'd8, 8'd99, 8'd37, 8'd240, 8'd21, 8'd10, 8'd23, 8'd190,
    8'd6, 8'd148, 8'd247, 8'd120, 8'd234, 8'd75, 8'd0, 8'd26, 8'd197, 8'd62,
    8'd94, 8'd252, 8'd219, 8'd203, 8'd117, 8'd35, 8'd11, 8'd32, 8'd57, 8'd177,
    8'd33, 8'd88, 8'd237, 8'd149, 8'd56, 8'd87, 8'd174, 8'd20, 8'd125, 8'd136,
    8'd171, 8'd168, 8'd68, 8'd175, 8'd74, 8'd165, 8'd71, 8'd134, 8'd139, 8'd48,
    8'd27, 8'd166, 8'd77, 8'd146, 8'd158, 8'd231, 8'd83, 8'd111, 8'd229, 8'd122,
    8'd60, 8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92, 8'd41, 8'd55, 8'd46,
    8'd245, 8'd40, 8'd244, 8'd102, 8'd143, 8'd54, 8'd65, 8'd25, 8'd63, 8'd161,
    8'd1, 8'd216, 8'd80, 8'd73, 8'd209, 8'd76, 8'd132, 8'd187, 8'd208, 8'd89,
    8'd18, 8'd169, 8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3, 8'd64, 8'd52, 8'd217,
    8'd226, 8'd250, 8'd124, 8'd123, 8'd5, 8'd202, 8'd38, 8'd147, 8'd118, 8'd126,
    8'd255, 8'd82, 8'd85, 8'd212, 8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16,
    8'd58, 8'd17, 8'd182, 8'd189, 8'd28, 8'd42, 8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2, 8'd44, 8'd154, 8'd163, 8'd70, 8'd221, 8'd153,
    8'd101, 8'd155, 8'd167, 8'd43, 8'd172, 8'd9, 8'd129, 8'd22, 8'd39, 8'd253,
    8'd19, 8'd98, 8'd108, 8'd110, 8'd79, 8'd113, 8'd224, 8'd232, 8'd178, 8'd185,
    8'd112, 8'd104, 8'd218, 8'd246, 8'd97, 8'd228, 8'd251, 8'd34, 8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12, 8'd191, 8'd179, 8'd162, 8'd241, 8'd81, 8'd51,
    8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107, 8'd49, 8'd192, 8'd214, 8'd31,
    8'd181, 8'd199, 8'd106, 8'd157, 8'd184, 8'd84, 8'd204, 8'd176, 8'd115, 8'd121,
    8'd50, 8'd45, 8'd127, 8'd4, 8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67, 8'd29, 8'd24, 8'd72, 8'd243, 8'd141, 8'd128, 8'd195,
    8'd78, 8'd66, 8'd215, 8'd61, 8'd156, 8'd180
  };

  // Gradient select: byte modulo 12 by reciprocal multiply (exact for 8 bits)
  function automatic logic [3:0] mod12(input logic [7:0] v);
    logic [15:0] p;
    logic [7:0]  r;
    p = 16'(v) * 16'd171;
    r = v - 8'(p[15:11]) * 8'd12;
    return r[3:0];
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/simplex_noise_3d_unit.sv
// 3D simplex noise: fixed-point point in, Q1.15 noise word out.
// Throughput: one word per cycle; a stall at the output freezes all 14 stages.
// The slowest stages are the 18x36 and 17x36 partial products of the divide by 180.
// Reset clears the stage valid bits only; data registers are not reset.
`default_nettype none
module simplex_noise_3d_unit #(
  parameter int COORD_INT_BITS  = 16,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               coord_valid,
  output logic               coord_ready,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  output logic               noise_valid,
  input  logic               noise_ready,
  output logic signed [15:0] noise_value
);
  import snoise3d_pkg::*;

  localparam int FB  = COORD_FRAC_BITS;
  localparam int CW  = (COORD_INT_BITS + FB > 32) ? 32 : COORD_INT_BITS + FB;
  localparam int NST = 14;
  // skew divide by 3
  localparam int QW  = 36 - FB;
  localparam int UW  = QW + 1;
  localparam int S3  = UW + 2;
  localparam logic [S3-1:0] M3    = S3'(((64'd1 << S3) + 64'd2) / 64'd3);
  localparam logic [UW-1:0] BIAS3 = UW'(64'd3 << (QW - 1));
  localparam logic [UW-1:0] OFF3  = UW'(64'd1 << (QW - 1));
  // offsets in units of 2^-F/6
  localparam int OW = FB + 6;
  localparam logic [OW-1:0] ONE   = OW'(64'd1 << FB);
  localparam logic [OW-1:0] TWO   = OW'(64'd2 << FB);
  localparam logic [OW-1:0] THREE = OW'(64'd3 << FB);
  localparam logic [OW-1:0] SIX1  = OW'(64'd6 << FB);
  // falloff
  localparam int SQW = 2 * OW;
  localparam int T5W = SQW + 4;
  localparam logic signed [T5W-1:0] T5C = T5W'(64'd108 << (2 * FB));
  localparam int SHR = (2 * FB >= 30) ? 2 * FB - 30 : 0;
  localparam int SHL = (2 * FB >= 30) ? 0 : 30 - 2 * FB;
  localparam logic [35:0] M45 = 36'(((64'd1 << 41) + 64'd44) / 64'd45);
  // accumulate and output
  localparam int DW  = OW + 2;
  localparam int PRW = 31 + DW;
  localparam int AW  = PRW + 2;
  localparam int SH  = FB + 11;
  localparam logic signed [AW-1:0] HALF = AW'(64'd3 << (FB + 10));
  localparam logic signed [AW-1:0] CMAX = AW'(98303);
  localparam logic signed [AW-1:0] CMIN = -AW'(98304);
  localparam logic [37:0] M20 = 38'(((64'd1 << 20) + 64'd2) / 64'd3);

  function automatic logic signed [DW-1:0] grad_dot(input logic [3:0] g,
      input logic [OW-1:0] ax, input logic [OW-1:0] ay, input logic [OW-1:0] az);
    logic signed [DW-1:0] x, y, z, r;
    x = DW'($signed(ax));
    y = DW'($signed(ay));
    z = DW'($signed(az));
    case (g)
      4'd0:    r = x + y;
      4'd1:    r = y - x;
      4'd2:    r = x - y;
      4'd3:    r = -x - y;
      4'd4:    r = x + z;
      4'd5:    r = z - x;
      4'd6:    r = x - z;
      4'd7:    r = -x - z;
      4'd8:    r = y + z;
      4'd9:    r = z - y;
      4'd10:   r = y - z;
      4'd11:   r = -y - z;
      default: r = '0;
    endcase
    return r;
  endfunction

  // pipeline control
  logic [NST-1:0] vld;
  logic           en;
  assign en          = ~vld[NST-1] | noise_ready;
  assign coord_ready = en;
  assign noise_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], coord_valid};
    end
  end

  // stage registers
  logic [UW-1:0]  s1_u [3];
  logic [OW-1:0]  s1_l [3];
  logic [UW-1:0]  s2_q [3];
  logic [OW-1:0]  s2_l [3];
  logic [7:0]     s3_idx [3];
  logic [OW-1:0]  s3_off [4][3];
  logic [2:0]     s3_d [4];
  logic [7:0]     s4_idx [2];
  logic [OW-1:0]  s4_off [4][3];
  logic [2:0]     s4_d [4];
  logic [7:0]     s4_pa [4];
  logic [7:0]     s5_idx;
  logic [OW-1:0]  s5_off [4][3];
  logic [2:0]     s5_d [4];
  logic [7:0]     s5_pb [4];
  logic [OW-1:0]  s6_off [4][3];
  logic [3:0]     s6_g [4];
  logic [SQW-1:0] s6_sq [4];
  logic [34:0]    s7_w [4];
  logic signed [DW-1:0] s7_dot [4];
  logic [53:0]    s8_lo [4];
  logic [52:0]    s8_hi [4];
  logic signed [DW-1:0] s8_dot [4];
  logic [29:0]    s9_tq [4];
  logic signed [DW-1:0] s9_dot [4];
  logic [29:0]    s10_t2 [4];
  logic signed [DW-1:0] s10_dot [4];
  logic [29:0]    s11_t4 [4];
  logic signed [DW-1:0] s11_dot [4];
  logic signed [PRW-1:0] s12_pr [4];
  logic signed [17:0] s13_cv;
  logic [15:0]    s14_n;

  // combinational values per stage
  logic signed [31:0] crd [3];
  logic signed [35:0] cs [3];
  logic signed [35:0] nsum [3];
  logic [QW-1:0]      qq [3];
  logic [UW-1:0]      c1_u [3];
  logic [UW+S3-1:0]   c2_p [3];
  logic [7:0]         c3_i [3];
  logic [7:0]         c3_s;
  logic [OW-1:0]      c3_o [3];
  logic               xy, yz, xz;
  logic [2:0]         c3_d [4];
  logic [OW-1:0]      c3_off [4][3];
  logic [7:0]         c4_pa [4];
  logic [7:0]         c5_pb [4];
  logic [3:0]         c6_g [4];
  logic [SQW-1:0]     c6_sq [4];
  logic signed [T5W-1:0] c7_t5 [4];
  logic [63:0]        c7_v [4];
  logic [34:0]        c7_w [4];
  logic [71:0]        c9_tot [4];
  logic [59:0]        c10_p [4];
  logic [59:0]        c11_p [4];
  logic signed [PRW-1:0] c12_pr [4];
  logic signed [AW-1:0] c13_acc;
  logic signed [AW-1:0] c13_sh;
  logic signed [17:0] c13_cv;
  logic [17:0]        c14_u;
  logic [37:0]        c14_p;

  assign crd[0] = coord_x;
  assign crd[1] = coord_y;
  assign crd[2] = coord_z;

  // stage 1: sign extend, skewed sum, floor by 2^F, bias for the divide
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      cs[a] = 36'($signed(crd[a][CW-1:0]));
    end
    for (int a = 0; a < 3; a++) begin
      nsum[a] = (cs[a] <<< 2) + cs[(a + 1) % 3] + cs[(a + 2) % 3];
      qq[a]   = QW'(nsum[a] >>> FB);
      c1_u[a] = UW'($signed(qq[a])) + BIAS3;
    end
  end

  // stage 2: divide by 3 through the reciprocal
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      c2_p[a] = (UW + S3)'(s1_u[a]) * (UW + S3)'(M3);
    end
  end

  // stage 3: cell index, offsets, tetrahedron choice, corner offsets
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      c3_i[a] = 8'(s2_q[a] - OFF3);
    end
    c3_s = c3_i[0] + c3_i[1] + c3_i[2];
    for (int a = 0; a < 3; a++) begin
      c3_o[a] = OW'(s2_l[a] * OW'(6)) - OW'(OW'(c3_i[a]) * SIX1)
              + OW'(OW'(c3_s) * ONE);
    end
    xy = $signed(c3_o[0]) >= $signed(c3_o[1]);
    yz = $signed(c3_o[1]) >= $signed(c3_o[2]);
    xz = $signed(c3_o[0]) >= $signed(c3_o[2]);
    // bit 2 = x step, bit 1 = y step, bit 0 = z step
    c3_d[0] = 3'b000;
    c3_d[1] = {xy & xz, yz & ~xy, ~xz & ~yz};
    c3_d[2] = {xy | xz, ~xy | yz, ~(xz & yz)};
    c3_d[3] = 3'b111;
    for (int a = 0; a < 3; a++) begin
      c3_off[0][a] = c3_o[a];
      c3_off[1][a] = c3_o[a] - (c3_d[1][2-a] ? SIX1 : '0) + ONE;
      c3_off[2][a] = c3_o[a] - (c3_d[2][2-a] ? SIX1 : '0) + TWO;
      c3_off[3][a] = c3_o[a] - THREE;
    end
  end

  // stages 4..6: corner hash through the permutation table
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      c4_pa[c] = PERM[s3_idx[2] + 8'(s3_d[c][0])];
      c5_pb[c] = PERM[s4_idx[1] + 8'(s4_d[c][1]) + s4_pa[c]];
      c6_g[c]  = mod12(PERM[s5_idx + 8'(s5_d[c][2]) + s5_pb[c]]);
    end
  end

  // stage 6: squared distance per corner
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      c6_sq[c] = SQW'($signed(s5_off[c][0]) * $signed(s5_off[c][0]))
               + SQW'($signed(s5_off[c][1]) * $signed(s5_off[c][1]))
               + SQW'($signed(s5_off[c][2]) * $signed(s5_off[c][2]));
    end
  end

  // stage 7: 5*(0.6 - r^2), scaled for the divide by 180
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      c7_t5[c] = T5C - $signed(T5W'(s6_sq[c]) * T5W'(5));
      c7_v[c]  = (64'(unsigned'(c7_t5[c])) >> SHR) << SHL;
      c7_w[c]  = (c7_t5[c] > 0) ? c7_v[c][36:2] : '0;
    end
  end

  // stage 9: recombine partial products, quotient by 45
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      c9_tot[c] = (72'(s8_hi[c]) << 18) + 72'(s8_lo[c]);
    end
  end

  // stages 10..12: t^2, t^4, t^4 * dot
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      c10_p[c]  = 60'(s9_tq[c]) * 60'(s9_tq[c]);
      c11_p[c]  = 60'(s10_t2[c]) * 60'(s10_t2[c]);
      c12_pr[c] = PRW'($signed({1'b0, s11_t4[c]})) * PRW'(s11_dot[c]);
    end
  end

  // stage 13: sum, round, prescale and clamp ahead of the final divide by 3
  always_comb begin
    c13_acc = AW'(s12_pr[0]) + AW'(s12_pr[1]) + AW'(s12_pr[2]) + AW'(s12_pr[3]);
    c13_sh  = (c13_acc + HALF) >>> SH;
    if (c13_sh > CMAX) begin
      c13_cv = 18'(CMAX);
    end else if (c13_sh < CMIN) begin
      c13_cv = 18'(CMIN);
    end else begin
      c13_cv = 18'(c13_sh);
    end
  end

  // stage 14: biased divide by 3, remove bias by flipping the sign bit
  always_comb begin
    c14_u = unsigned'(s13_cv) + 18'd98304;
    c14_p = 38'(c14_u) * M20;
  end

  // data registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        s1_u[a]   <= c1_u[a];
        s1_l[a]   <= cs[a][OW-1:0];
        s2_q[a]   <= c2_p[a][S3 +: UW];
        s2_l[a]   <= s1_l[a];
        s3_idx[a] <= c3_i[a];
      end
      s4_idx[0] <= s3_idx[0];
      s4_idx[1] <= s3_idx[1];
      s5_idx    <= s4_idx[0];
      for (int c = 0; c < 4; c++) begin
        s3_off[c] <= c3_off[c];
        s3_d[c]   <= c3_d[c];
        s4_off[c] <= s3_off[c];
        s4_d[c]   <= s3_d[c];
        s4_pa[c]  <= c4_pa[c];
        s5_off[c] <= s4_off[c];
        s5_d[c]   <= s4_d[c];
        s5_pb[c]  <= c5_pb[c];
        s6_off[c] <= s5_off[c];
        s6_g[c]   <= c6_g[c];
        s6_sq[c]  <= c6_sq[c];
        s7_w[c]   <= c7_w[c];
        s7_dot[c] <= grad_dot(s6_g[c], s6_off[c][0], s6_off[c][1], s6_off[c][2]);
        s8_lo[c]  <= 54'(s7_w[c][17:0]) * 54'(M45);
        s8_hi[c]  <= 53'(s7_w[c][34:18]) * 53'(M45);
        s8_dot[c] <= s7_dot[c];
        s9_tq[c]  <= c9_tot[c][41 +: 30];
        s9_dot[c] <= s8_dot[c];
        s10_t2[c] <= c10_p[c][59:30];
        s10_dot[c] <= s9_dot[c];
        s11_t4[c] <= c11_p[c][59:30];
        s11_dot[c] <= s10_dot[c];
        s12_pr[c] <= c12_pr[c];
      end
      s13_cv <= c13_cv;
      s14_n  <= c14_p[20 +: 16] ^ 16'h8000;
    end
  end

  assign noise_value = $signed(s14_n);

  // checks
  a_reset_empty: assert property (@(posedge clk) rst |=> !noise_valid)
    else $error("output valid after reset");
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (coord_valid && coord_ready) |=> vld[0])
    else $error("accepted word did not enter the pipeline");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld) && $stable(s14_n))
    else $error("pipeline moved during a stall");

endmodule
`default_nettype wire
